### rtl/core/msios_pkg.sv
`timescale 1ns / 1ps
package msios_pkg;

  localparam int DEVICES_DEF = 4;
  localparam int SLOTS_DEF   = 4;
  localparam int PROCS_DEF   = 16;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 64;

  typedef enum logic [1:0] {
    REG_DEVICE_COUNT  = 2'd0,
    REG_SLOT_LIMITS   = 2'd1,
    REG_SERVICE_TIMES = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    EV_STARTED    = 3'd0,
    EV_QUEUED     = 3'd1,
    EV_REJECTED   = 3'd2,
    EV_FINISHED   = 3'd3,
    EV_FROM_QUEUE = 3'd4,
    EV_TICK_DONE  = 3'd5
  } event_t;

  typedef enum logic [3:0] {
    OP_NONE     = 4'd0,
    OP_LOAD     = 4'd1,
    OP_REQ      = 4'd2,
    OP_SLOT_RD  = 4'd3,
    OP_REM_RD   = 4'd4,
    OP_FIN      = 4'd5,
    OP_MOVE     = 4'd6,
    OP_DEC      = 4'd7,
    OP_RING_RD  = 4'd8,
    OP_REFILL   = 4'd9,
    OP_DEV_NEXT = 4'd10,
    OP_DONE     = 4'd11
  } dp_op_t;

  typedef struct packed {
    logic dev_more;
    logic slot_more;
    logic rem_le1;
    logic refill_more;
    logic out_free;
  } dp_status_t;

  // Slot limit of a device, clamped to the slot count; devices past the
  // packed field have no slots.
  function automatic logic [2:0] limit_of(logic [11:0] lims, logic [2:0] dev, int slots);
    logic [2:0] v;
    case (dev)
      3'd0: v = lims[2:0];
      3'd1: v = lims[5:3];
      3'd2: v = lims[8:6];
      3'd3: v = lims[11:9];
      default: v = 3'd0;
    endcase
    if (32'(v) > slots) v = 3'(slots);
    return v;
  endfunction

  // Service time of a device; zero counts as one tick.
  function automatic logic [15:0] service_of(logic [63:0] st, logic [2:0] dev);
    logic [15:0] v;
    case (dev)
      3'd0: v = st[15:0];
      3'd1: v = st[31:16];
      3'd2: v = st[47:32];
      3'd3: v = st[63:48];
      default: v = 16'd1;
    endcase
    if (v == 16'd0) v = 16'd1;
    return v;
  endfunction

endpackage

### rtl/core/msios_if.sv
`timescale 1ns / 1ps
interface msios_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [3:0]  proc_id;
  logic [2:0]  dev_sel;
  logic [31:0] now;
  modport source (output valid, cmd, proc_id, dev_sel, now, input ready);
  modport sink (input valid, cmd, proc_id, dev_sel, now, output ready);
endinterface

interface msios_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [3:0]  proc_out;
  logic [2:0]  device_out;
  logic [31:0] waited;
  logic        last;
  modport source (output valid, event_res, proc_out, device_out, waited, last, input ready);
  modport sink (input valid, event_res, proc_out, device_out, waited, last, output ready);
endinterface

### rtl/core/msios_ctrl.sv
`timescale 1ns / 1ps
module msios_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_cmd,
  output logic                  in_ready,
  input  msios_pkg::dp_status_t status,
  output msios_pkg::dp_op_t     op
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_REQ    = 10'b0000000010,
    S_DEV    = 10'b0000000100,
    S_SCAN   = 10'b0000001000,
    S_REM    = 10'b0000010000,
    S_EVAL   = 10'b0000100000,
    S_MOVE   = 10'b0001000000,
    S_RING   = 10'b0010000000,
    S_REFILL = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    op        = msios_pkg::OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op        = msios_pkg::OP_LOAD;
          state_nxt = in_cmd ? S_DEV : S_REQ;
        end
      end
      S_REQ: begin
        if (status.out_free) begin
          op        = msios_pkg::OP_REQ;
          state_nxt = S_IDLE;
        end
      end
      S_DEV: state_nxt = status.dev_more ? S_SCAN : S_DONE;
      S_SCAN: begin
        if (status.slot_more) begin
          op        = msios_pkg::OP_SLOT_RD;
          state_nxt = S_REM;
        end else begin
          state_nxt = S_RING;
        end
      end
      S_REM: begin
        op        = msios_pkg::OP_REM_RD;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (status.rem_le1) begin
          if (status.out_free) begin
            op        = msios_pkg::OP_FIN;
            state_nxt = S_MOVE;
          end
        end else begin
          op        = msios_pkg::OP_DEC;
          state_nxt = S_SCAN;
        end
      end
      S_MOVE: begin
        op        = msios_pkg::OP_MOVE;
        state_nxt = S_SCAN;
      end
      S_RING: begin
        if (status.refill_more) begin
          op        = msios_pkg::OP_RING_RD;
          state_nxt = S_REFILL;
        end else begin
          op        = msios_pkg::OP_DEV_NEXT;
          state_nxt = S_DEV;
        end
      end
      S_REFILL: begin
        if (status.out_free) begin
          op        = msios_pkg::OP_REFILL;
          state_nxt = S_RING;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          op        = msios_pkg::OP_DONE;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

### rtl/core/msios_dp.sv
`timescale 1ns / 1ps
module msios_dp #(
  parameter int DEVICES = msios_pkg::DEVICES_DEF,
  parameter int SLOTS   = msios_pkg::SLOTS_DEF,
  parameter int PROCS   = msios_pkg::PROCS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  msios_pkg::dp_op_t     op,
  output msios_pkg::dp_status_t status,
  input  logic                  in_cmd,
  input  logic [3:0]            in_proc_id,
  input  logic [2:0]            in_dev_sel,
  input  logic [31:0]           in_now,
  input  logic [2:0]            device_count,
  input  logic [11:0]           slot_limits,
  input  logic [63:0]           service_times,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [2:0]            out_event_res,
  output logic [3:0]            out_proc_out,
  output logic [2:0]            out_device_out,
  output logic [31:0]           out_waited,
  output logic                  out_last
);

  localparam int DW    = (DEVICES > 1) ? $clog2(DEVICES) : 1;
  localparam int DCW   = $clog2(DEVICES + 1);
  localparam int UCW   = $clog2(SLOTS + 1);
  localparam int PW    = $clog2(PROCS);
  localparam int RCW   = $clog2(PROCS + 1);
  localparam int AL_D  = DEVICES * SLOTS;
  localparam int AL_AW = (AL_D > 1) ? $clog2(AL_D) : 1;
  localparam int RG_D  = DEVICES * PROCS;
  localparam int RG_AW = $clog2(RG_D);

  // Latched request.
  logic        cmd_r;
  logic [3:0]  proc_r;
  logic [2:0]  dev_r;
  logic [31:0] now_r;

  // Tick walk position.
  logic [DCW-1:0] d_r;
  logic [UCW-1:0] i_r;
  logic [3:0]     p_r;

  // Per-device counters.
  logic [UCW-1:0] uc_r   [DEVICES];
  logic [PW-1:0]  head_r [DEVICES];
  logic [PW-1:0]  tail_r [DEVICES];
  logic [RCW-1:0] rc_r   [DEVICES];

  // Stores.
  logic [3:0]  al_mem   [AL_D];
  logic [15:0] rem_mem  [PROCS];
  logic [31:0] rt_mem   [PROCS];
  logic [3:0]  ring_mem [RG_D];
  logic [3:0]  al_q;
  logic [15:0] rem_q;
  logic [31:0] rt_q;
  logic [3:0]  ring_q;

  logic                 out_valid_r;
  msios_pkg::event_t    out_ev_r;
  logic [3:0]           out_proc_r;
  logic [2:0]           out_dev_r;
  logic [31:0]          out_waited_r;
  logic                 out_last_r;

  logic [DW-1:0]  cd;
  logic [2:0]     cur_dev;
  logic [UCW-1:0] uc;
  logic [PW-1:0]  head, tail;
  logic [RCW-1:0] rc;
  logic [2:0]     lim;
  logic [15:0]    svc;
  logic [DCW-1:0] nd;
  logic           bad, can_start, ring_full, out_free, emit;
  logic [PW-1:0]  pidx_in, pidx_cur, pidx_ring, pidx_al;
  logic [AL_AW-1:0] al_raddr, al_slot_addr, al_top_addr, al_last_addr;
  logic [RG_AW-1:0] rg_head_addr, rg_tail_addr;

  assign cd      = cmd_r ? d_r[DW-1:0] : dev_r[DW-1:0];
  assign cur_dev = cmd_r ? 3'(d_r) : dev_r;
  assign uc      = uc_r[cd];
  assign head    = head_r[cd];
  assign tail    = tail_r[cd];
  assign rc      = rc_r[cd];
  assign lim     = msios_pkg::limit_of(slot_limits, cur_dev, SLOTS);
  assign svc     = msios_pkg::service_of(service_times, cur_dev);
  assign nd      = (32'(device_count) > DEVICES) ? DCW'(DEVICES) : DCW'(device_count);

  assign bad       = (32'(dev_r) >= 32'(nd)) || (32'(proc_r) >= PROCS);
  assign can_start = 32'(uc) < 32'(lim);
  assign ring_full = 32'(rc) >= PROCS;
  assign out_free  = !out_valid_r || out_ready;

  assign pidx_in   = PW'(proc_r);
  assign pidx_cur  = PW'(p_r);
  assign pidx_ring = PW'(ring_q);
  assign pidx_al   = PW'(al_q);

  assign al_slot_addr = AL_AW'(int'(cd) * SLOTS + int'(i_r));
  assign al_top_addr  = AL_AW'(int'(cd) * SLOTS + int'(uc));
  assign al_last_addr = AL_AW'(int'(cd) * SLOTS + int'(uc) - 1);
  assign al_raddr     = (op == msios_pkg::OP_FIN) ? al_last_addr : al_slot_addr;
  assign rg_head_addr = RG_AW'(int'(cd) * PROCS + int'(head));
  assign rg_tail_addr = RG_AW'(int'(cd) * PROCS + int'(tail));

  assign status.dev_more    = d_r < nd;
  assign status.slot_more   = i_r < uc;
  assign status.rem_le1     = rem_q <= 16'd1;
  assign status.refill_more = can_start && (rc != '0);
  assign status.out_free    = out_free;

  function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] ptr);
    return (ptr == PW'(PROCS - 1)) ? '0 : ptr + 1'b1;
  endfunction

  always_comb begin
    case (op)
      msios_pkg::OP_REQ, msios_pkg::OP_FIN, msios_pkg::OP_REFILL,
      msios_pkg::OP_DONE: emit = 1'b1;
      default:            emit = 1'b0;
    endcase
  end

  // Stores: one read port with registered data and one write port each.
  always_ff @(posedge clk) begin
    if (op == msios_pkg::OP_SLOT_RD || op == msios_pkg::OP_FIN) al_q <= al_mem[al_raddr];
    if (op == msios_pkg::OP_REQ && !bad && can_start) al_mem[al_top_addr] <= proc_r;
    else if (op == msios_pkg::OP_MOVE)                al_mem[al_slot_addr] <= al_q;
    else if (op == msios_pkg::OP_REFILL)              al_mem[al_top_addr] <= ring_q;
  end

  always_ff @(posedge clk) begin
    if (op == msios_pkg::OP_REM_RD) begin
      rem_q <= rem_mem[pidx_al];
      rt_q  <= rt_mem[pidx_al];
    end
    if (op == msios_pkg::OP_REQ && !bad && can_start) rem_mem[pidx_in] <= svc;
    else if (op == msios_pkg::OP_FIN)                 rem_mem[pidx_cur] <= 16'd0;
    else if (op == msios_pkg::OP_DEC)                 rem_mem[pidx_cur] <= rem_q - 16'd1;
    else if (op == msios_pkg::OP_REFILL)              rem_mem[pidx_ring] <= svc;
    if (op == msios_pkg::OP_REQ && !bad && (can_start || !ring_full))
      rt_mem[pidx_in] <= now_r;
  end

  always_ff @(posedge clk) begin
    if (op == msios_pkg::OP_RING_RD) ring_q <= ring_mem[rg_head_addr];
    if (op == msios_pkg::OP_REQ && !bad && !can_start && !ring_full)
      ring_mem[rg_tail_addr] <= proc_r;
  end

  // Latched request and process under test.
  always_ff @(posedge clk) begin
    if (op == msios_pkg::OP_LOAD) begin
      cmd_r  <= in_cmd;
      proc_r <= in_proc_id;
      dev_r  <= in_dev_sel;
      now_r  <= in_now;
    end
    if (op == msios_pkg::OP_REM_RD) p_r <= al_q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r <= '0;
      i_r <= '0;
      for (int k = 0; k < DEVICES; k++) begin
        uc_r[k]   <= '0;
        head_r[k] <= '0;
        tail_r[k] <= '0;
        rc_r[k]   <= '0;
      end
    end else begin
      case (op)
        msios_pkg::OP_LOAD: begin
          d_r <= '0;
          i_r <= '0;
        end
        msios_pkg::OP_REQ: begin
          if (!bad && can_start) begin
            uc_r[cd] <= uc + 1'b1;
          end else if (!bad && !ring_full) begin
            tail_r[cd] <= ptr_inc(tail);
            rc_r[cd]   <= rc + 1'b1;
          end
        end
        msios_pkg::OP_DEC:  i_r <= i_r + 1'b1;
        // The last slot has moved into the finished one; shrink the list.
        msios_pkg::OP_MOVE: uc_r[cd] <= uc - 1'b1;
        msios_pkg::OP_REFILL: begin
          uc_r[cd]   <= uc + 1'b1;
          head_r[cd] <= ptr_inc(head);
          rc_r[cd]   <= rc - 1'b1;
        end
        msios_pkg::OP_DEV_NEXT: begin
          d_r <= d_r + 1'b1;
          i_r <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (emit) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    case (op)
      msios_pkg::OP_REQ: begin
        if (bad || (!can_start && ring_full)) out_ev_r <= msios_pkg::EV_REJECTED;
        else if (can_start)                   out_ev_r <= msios_pkg::EV_STARTED;
        else                                  out_ev_r <= msios_pkg::EV_QUEUED;
        out_proc_r   <= proc_r;
        out_dev_r    <= dev_r;
        out_waited_r <= 32'd0;
        out_last_r   <= 1'b1;
      end
      msios_pkg::OP_FIN: begin
        out_ev_r     <= msios_pkg::EV_FINISHED;
        out_proc_r   <= p_r;
        out_dev_r    <= cur_dev;
        out_waited_r <= now_r - rt_q;
        out_last_r   <= 1'b0;
      end
      msios_pkg::OP_REFILL: begin
        out_ev_r     <= msios_pkg::EV_FROM_QUEUE;
        out_proc_r   <= ring_q;
        out_dev_r    <= cur_dev;
        out_waited_r <= 32'd0;
        out_last_r   <= 1'b0;
      end
      msios_pkg::OP_DONE: begin
        out_ev_r     <= msios_pkg::EV_TICK_DONE;
        out_proc_r   <= 4'd0;
        out_dev_r    <= 3'd0;
        out_waited_r <= 32'd0;
        out_last_r   <= 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_event_res  = out_ev_r;
  assign out_proc_out   = out_proc_r;
  assign out_device_out = out_dev_r;
  assign out_waited     = out_waited_r;
  assign out_last       = out_last_r;

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n) emit |-> out_free)
    else $error("result written over one not yet taken");
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (op == msios_pkg::OP_DONE) |=> (out_valid_r && out_last_r))
    else $error("tick done not presented as final result");
  a_move_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (op == msios_pkg::OP_MOVE) |-> (uc != '0))
    else $error("slot removed from an empty device");
  a_refill_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (op == msios_pkg::OP_REFILL) |-> (rc != '0))
    else $error("refill taken from an empty wait ring");

endmodule

### rtl/core/multi_device_io_slot_scheduler.sv
`timescale 1ns / 1ps
// Slot scheduler for several devices: a request takes a free service slot on
// its device or joins that device's FIFO wait ring (bad device or full ring is
// rejected); a tick counts down every active slot, reports finished ones,
// refills from the rings and ends with a tick-done result. One item is
// handled at a time. A tick is walked by the controller one slot per step
// through the slot, countdown and ring memories (one read port each), and
// every result waits while the result consumer holds off. The next request
// is accepted while the last result still waits in the output register.
module multi_device_io_slot_scheduler #(
  parameter int DEVICES = msios_pkg::DEVICES_DEF,
  parameter int SLOTS   = msios_pkg::SLOTS_DEF,
  parameter int PROCS   = msios_pkg::PROCS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  msios_in_if.sink                       in_if,
  msios_out_if.source                    out_if,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [msios_pkg::CFG_AW-1:0]   paddr,
  input  logic [msios_pkg::CFG_DW-1:0]   pwdata,
  output logic [msios_pkg::CFG_DW-1:0]   prdata,
  output logic                           pready
);

  logic [2:0]  device_count_r;
  logic [11:0] slot_limits_r;
  logic [63:0] service_times_r;

  msios_pkg::reg_idx_t   reg_idx;
  msios_pkg::dp_status_t status;
  msios_pkg::dp_op_t     op;
  logic                  cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = msios_pkg::reg_idx_t'(paddr[4:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_count_r  <= '0;
      slot_limits_r   <= '0;
      service_times_r <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        msios_pkg::REG_DEVICE_COUNT:  device_count_r  <= pwdata[2:0];
        msios_pkg::REG_SLOT_LIMITS:   slot_limits_r   <= pwdata[11:0];
        msios_pkg::REG_SERVICE_TIMES: service_times_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      msios_pkg::REG_DEVICE_COUNT:  prdata = {61'd0, device_count_r};
      msios_pkg::REG_SLOT_LIMITS:   prdata = {52'd0, slot_limits_r};
      msios_pkg::REG_SERVICE_TIMES: prdata = service_times_r;
      default:                      prdata = '0;
    endcase
  end

  msios_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_cmd   (in_if.cmd),
    .in_ready (in_if.ready),
    .status   (status),
    .op       (op)
  );

  msios_dp #(
    .DEVICES (DEVICES),
    .SLOTS   (SLOTS),
    .PROCS   (PROCS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .op             (op),
    .status         (status),
    .in_cmd         (in_if.cmd),
    .in_proc_id     (in_if.proc_id),
    .in_dev_sel     (in_if.dev_sel),
    .in_now         (in_if.now),
    .device_count   (device_count_r),
    .slot_limits    (slot_limits_r),
    .service_times  (service_times_r),
    .out_ready      (out_if.ready),
    .out_valid      (out_if.valid),
    .out_event_res  (out_if.event_res),
    .out_proc_out   (out_if.proc_out),
    .out_device_out (out_if.device_out),
    .out_waited     (out_if.waited),
    .out_last       (out_if.last)
  );

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam int NDEV  = msios_pkg::DEVICES_DEF;
  localparam int NSLOT = msios_pkg::SLOTS_DEF;
  localparam int NPROC = msios_pkg::PROCS_DEF;

  typedef enum logic {
    CMD_REQUEST = 1'b0,
    CMD_TICK    = 1'b1
  } sched_cmd_t;

  typedef struct packed {
    msios_pkg::event_t ev;
    logic [3:0]  proc_n;
    logic [2:0]  dev_n;
    logic [31:0] waited;
    logic        last;
  } sched_event_t;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite, pready;
  logic [msios_pkg::CFG_AW-1:0] paddr;
  logic [msios_pkg::CFG_DW-1:0] pwdata, prdata;

  msios_in_if  in_ch ();
  msios_out_if out_ch ();

  multi_device_io_slot_scheduler DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Mirror of the scheduler configuration and state.
  logic [2:0]  cfg_devices;
  logic [11:0] cfg_limits;
  logic [63:0] cfg_service;
  logic [3:0]  slot_proc [NDEV][NSLOT];
  logic [15:0] ticks_left [NPROC];
  int unsigned busy_slots [NDEV];
  logic [3:0]  wait_fifo [NDEV][NPROC];
  int unsigned fifo_head [NDEV];
  int unsigned fifo_tail [NDEV];
  int unsigned fifo_fill [NDEV];
  logic [31:0] req_stamp [NPROC];

  sched_event_t pending_events[$];
  int unsigned  errors;
  int unsigned  send_idle_pct;
  int unsigned  recv_stall_pct;
  logic [31:0]  clock_now;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int unsigned devices_active();
    return (cfg_devices > NDEV) ? NDEV : cfg_devices;
  endfunction

  function automatic int unsigned slot_cap(int unsigned d);
    int unsigned v;
    v = (cfg_limits >> (3 * d)) & 3'h7;
    return (v > NSLOT) ? NSLOT : v;
  endfunction

  function automatic logic [15:0] service_ticks(int unsigned d);
    logic [15:0] v;
    v = cfg_service[16*d +: 16];
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  function automatic void push_event(msios_pkg::event_t ev, logic [3:0] p, logic [2:0] d,
                                     logic [31:0] w, logic last);
    sched_event_t e;
    e.ev = ev;
    e.proc_n = p;
    e.dev_n = d;
    e.waited = w;
    e.last = last;
    pending_events.push_back(e);
  endfunction

  function automatic void predict_schedule(logic cmd, logic [3:0] p, logic [2:0] d,
                                           logic [31:0] now);
    int unsigned i;
    int unsigned dv;
    logic [3:0] q;
    if (cmd == CMD_REQUEST) begin
      if (d >= devices_active()) begin
        push_event(msios_pkg::EV_REJECTED, p, d, 0, 1'b1);
      end else if (busy_slots[d] < slot_cap(d)) begin
        req_stamp[p] = now;
        ticks_left[p] = service_ticks(d);
        slot_proc[d][busy_slots[d]] = p;
        busy_slots[d]++;
        push_event(msios_pkg::EV_STARTED, p, d, 0, 1'b1);
      end else if (fifo_fill[d] >= NPROC) begin
        push_event(msios_pkg::EV_REJECTED, p, d, 0, 1'b1);
      end else begin
        req_stamp[p] = now;
        wait_fifo[d][fifo_tail[d]] = p;
        fifo_tail[d] = (fifo_tail[d] + 1) % NPROC;
        fifo_fill[d]++;
        push_event(msios_pkg::EV_QUEUED, p, d, 0, 1'b1);
      end
    end else begin
      for (dv = 0; dv < devices_active(); dv++) begin
        i = 0;
        while (i < busy_slots[dv] && i < NSLOT) begin
          q = slot_proc[dv][i];
          if (ticks_left[q] <= 16'd1) begin
            ticks_left[q] = 16'd0;
            push_event(msios_pkg::EV_FINISHED, q, 3'(dv), now - req_stamp[q], 1'b0);
            slot_proc[dv][i] = slot_proc[dv][busy_slots[dv] - 1];
            busy_slots[dv]--;
          end else begin
            ticks_left[q]--;
            i++;
          end
        end
        while (busy_slots[dv] < slot_cap(dv) && fifo_fill[dv] > 0) begin
          q = wait_fifo[dv][fifo_head[dv]];
          fifo_head[dv] = (fifo_head[dv] + 1) % NPROC;
          fifo_fill[dv]--;
          ticks_left[q] = service_ticks(dv);
          slot_proc[dv][busy_slots[dv]] = q;
          busy_slots[dv]++;
          push_event(msios_pkg::EV_FROM_QUEUE, q, 3'(dv), 0, 1'b0);
        end
      end
      push_event(msios_pkg::EV_TICK_DONE, 4'd0, 3'd0, 0, 1'b1);
    end
  endfunction

  task automatic report(string what, logic [31:0] exp_v, logic [31:0] got_v);
    $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, exp_v, got_v);
    errors++;
  endtask

  // Result checker and receiver stall generator.
  always @(posedge clk) begin
    sched_event_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_events.size() == 0) begin
        report("unexpected result, event", 0, out_ch.event_res);
      end else begin
        e = pending_events.pop_front();
        if (out_ch.event_res !== e.ev) report("event", e.ev, out_ch.event_res);
        if (out_ch.proc_out !== e.proc_n) report("process", e.proc_n, out_ch.proc_out);
        if (out_ch.device_out !== e.dev_n) report("device", e.dev_n, out_ch.device_out);
        if (out_ch.waited !== e.waited) report("waited", e.waited, out_ch.waited);
        if (out_ch.last !== e.last) report("last", e.last, out_ch.last);
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_request(logic cmd, logic [3:0] p, logic [2:0] d, logic [31:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.proc_id <= p;
    in_ch.dev_sel <= d;
    in_ch.now <= now;
    do @(posedge clk); while (!in_ch.ready);
    predict_schedule(cmd, p, d, now);
  endtask

  // Let every outstanding result come back before touching the registers.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(msios_pkg::reg_idx_t idx, logic [63:0] value);
    logic [63:0] exp_val;
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= msios_pkg::CFG_AW'(8 * int'(idx));
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    exp_val = '0;
    case (idx)
      msios_pkg::REG_DEVICE_COUNT: begin
        cfg_devices = value[2:0];
        exp_val = {61'd0, value[2:0]};
      end
      msios_pkg::REG_SLOT_LIMITS: begin
        cfg_limits = value[11:0];
        exp_val = {52'd0, value[11:0]};
      end
      msios_pkg::REG_SERVICE_TIMES: begin
        cfg_service = value;
        exp_val = value;
      end
      default: ;
    endcase
    // The address is still held, so the read data shows the new value.
    @(posedge clk);
    if (prdata !== exp_val) report("register readback", exp_val[31:0], prdata[31:0]);
  endtask

  task automatic configure(logic [2:0] n, logic [11:0] lims, logic [63:0] svc);
    write_reg(msios_pkg::REG_DEVICE_COUNT, 64'(n));
    write_reg(msios_pkg::REG_SLOT_LIMITS, 64'(lims));
    write_reg(msios_pkg::REG_SERVICE_TIMES, svc);
  endtask

  task automatic request(logic [3:0] p, logic [2:0] d);
    clock_now += $urandom_range(1, 40);
    send_request(CMD_REQUEST, p, d, clock_now);
  endtask

  task automatic tick();
    clock_now += $urandom_range(1, 40);
    send_request(CMD_TICK, 4'd0, 3'd0, clock_now);
  endtask

  // Out of reset no device is in use: every request is rejected.
  task automatic test_reset_state();
    request(4'd0, 3'd0);
    request(4'd15, 3'd7);
    tick();
  endtask

  task automatic test_directed();
    // Count above the device total acts as the total; limits above the slot
    // count act as the slot count; zero service time acts as one tick.
    configure(3'd7, 12'hFFF, 64'h0000_0003_FFFF_0000);
    request(4'd15, 3'd0);
    request(4'd0, 3'd1);
    request(4'd7, 3'd4);
    request(4'd8, 3'd7);
    request(4'd1, 3'd3);
    request(4'd1, 3'd3);
    for (int k = 2; k < 7; k++) request(4'(k), 3'd0);
    tick();
    send_request(CMD_REQUEST, 4'd9, 3'd2, 32'hFFFF_FFFF);
    send_request(CMD_REQUEST, 4'd10, 3'd2, 32'hFFFF_FFF0);
    send_request(CMD_TICK, 4'd5, 3'd6, 32'h0000_0005);
    clock_now = 32'h0000_0010;
    tick();
    tick();
    tick();
  endtask

  // With no slots a device only queues, so its ring fills up.
  task automatic test_full_ring();
    configure(3'd1, 12'h000, 64'h1);
    for (int k = 0; k <= NPROC; k++) request(4'(k), 3'd0);
    tick();
    write_reg(msios_pkg::REG_SLOT_LIMITS, 64'h004);
    tick();
    tick();
    tick();
  endtask

  task automatic test_limit_lowered();
    configure(3'd2, 12'h01C, 64'h0002_0004);
    for (int k = 0; k < 6; k++) request(4'(k), 3'(k % 2));
    write_reg(msios_pkg::REG_SLOT_LIMITS, 64'h009);
    write_reg(msios_pkg::REG_DEVICE_COUNT, 64'd1);
    request(4'd6, 3'd1);
    for (int k = 0; k < 4; k++) tick();
    write_reg(msios_pkg::REG_DEVICE_COUNT, 64'd2);
    for (int k = 0; k < 4; k++) tick();
  endtask

  task automatic test_random(int unsigned idle, int unsigned stall, int unsigned count);
    logic [63:0] svc;
    int unsigned nd;
    for (int k = 0; k < 4; k++)
      svc[16*k +: 16] = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
    configure(3'($urandom_range(1, 7)), 12'($urandom), svc);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    nd = devices_active();
    for (int unsigned k = 0; k < count; k++) begin
      if ($urandom_range(99) < 30) begin
        if ($urandom_range(19) == 0)
          send_request(CMD_TICK, 4'($urandom), 3'($urandom), $urandom);
        else
          tick();
      end else if ($urandom_range(99) < 85 && nd > 0) begin
        request(4'($urandom), 3'($urandom_range(0, nd - 1)));
      end else if ($urandom_range(9) == 0) begin
        send_request(CMD_REQUEST, 4'($urandom), 3'($urandom), $urandom);
      end else begin
        request(4'($urandom), 3'($urandom));
      end
      // Hold off once in a while until all results are back.
      if ($urandom_range(49) == 0) drain();
    end
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_REQUEST;
    in_ch.proc_id = '0;
    in_ch.dev_sel = '0;
    in_ch.now = '0;
    out_ch.ready = 1'b0;
    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    clock_now = 32'd100;
    cfg_devices = '0;
    cfg_limits = '0;
    cfg_service = '0;
    for (int d = 0; d < NDEV; d++) begin
      busy_slots[d] = 0;
      fifo_head[d] = 0;
      fifo_tail[d] = 0;
      fifo_fill[d] = 0;
    end
    for (int p = 0; p < NPROC; p++) begin
      ticks_left[p] = '0;
      req_stamp[p] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_directed();
    test_full_ring();
    test_limit_lowered();
    test_random(0, 0, 55);
    test_random(65, 0, 55);
    test_random(0, 65, 55);
    test_random(36, 36, 55);

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
